// ----- design/assert_macros.svh -----
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/bptc_pkg.sv -----
`default_nettype none

package bptc_pkg;

    localparam int CAL_W    = 16;
    localparam int RAW_W    = 24;
    localparam int RES_W    = 32;
    localparam int IDX_W    = 3;
    localparam int N_STAGE  = 8;

    // intermediate widths, signed except the low sensitivity half and its product (LO_W, PPL_W)
    localparam int DT_W     = 25;
    localparam int MT_W     = 42;
    localparam int OFF_W    = 37;
    localparam int SENS_W   = 36;
    localparam int LO_W     = 17;
    localparam int HI_W     = SENS_W - LO_W;
    localparam int PPL_W    = RAW_W + LO_W;
    localparam int PPH_W    = RAW_W + 1 + HI_W;
    localparam int PROD_W   = 61;
    localparam int Q_W      = 40;
    localparam int X_W      = 41;

    localparam int TEMP_BASE  = 2000;
    localparam int C5_SHIFT   = 8;
    localparam int T_SHIFT    = 23;
    localparam int C2_SHIFT   = 17;
    localparam int OFF_SHIFT  = 6;
    localparam int C1_SHIFT   = 16;
    localparam int SENS_SHIFT = 7;
    localparam int P1_SHIFT   = 21;
    localparam int P2_SHIFT   = 15;

    typedef enum logic [IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

endpackage

`default_nettype wire

// ----- design/bptc_cal_regs.sv -----
`default_nettype none

module bptc_cal_regs import bptc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_index,
    input  wire logic [CAL_W-1:0] i_wr_data,
    output t_cal                  o_cal
);

    t_cal r_cal;
    t_cal n_cal;

    always_comb begin
        n_cal = r_cal;
        if (i_wr_en) begin
            unique case (t_reg_idx'(i_wr_index))
                REG_C1:  n_cal.c1 = i_wr_data;
                REG_C2:  n_cal.c2 = i_wr_data;
                REG_C3:  n_cal.c3 = i_wr_data;
                REG_C4:  n_cal.c4 = i_wr_data;
                REG_C5:  n_cal.c5 = i_wr_data;
                REG_C6:  n_cal.c6 = i_wr_data;
                default: n_cal = r_cal;   // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

`default_nettype wire

// ----- design/baro_pressure_temp_compensation.sv -----
// Channel  | dir | handshake                      | payload
// -------- | --- | ------------------------------ | ---------------------------------------
// sample   | in  | s_axis_tvalid / s_axis_tready  | s_axis_tdata: raw_pressure, raw_temp
// result   | out | m_axis_tvalid / m_axis_tready  | m_axis_tdata: temperature, pressure
// config   | in  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Eight-stage pipeline, one word per cycle while the output is not stalled; m_axis_tvalid is the stage-8 valid bit.
// Stage chain: dT, three 25x17 products, temperature and offset/sensitivity sums,
// split 24x36 pressure product, product sum, two shifts and one subtract.
// Synchronous active-low reset clears valid bits and calibration words.
// A stall at the output freezes the whole pipeline; s_axis_tready drops with it.
`default_nettype none
`include "assert_macros.svh"

module baro_pressure_temp_compensation import bptc_pkg::*; #(
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [47:0]      s_axis_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [63:0]           m_axis_tdata,   // [31:0] temperature_centi, [63:32] pressure_comp
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CAL_W-1:0] i_cfg_data
);

    t_cal w_cal;
    logic w_en;

    logic [N_STAGE-1:0] r_vld;

    // payload registers per stage
    logic [RAW_W-1:0]         r_d1_s1, r_d1_s2, r_d1_s3;
    logic signed [DT_W-1:0]   r_dt;
    logic signed [MT_W-1:0]   r_mt, r_mo, r_ms;
    logic [RES_W-1:0]         r_temp_s3, r_temp_s4, r_temp_s5, r_temp_s6, r_temp_s7;
    logic signed [OFF_W-1:0]  r_off_s3, r_off_s4, r_off_s5, r_off_s6;
    logic signed [SENS_W-1:0] r_sens;
    logic [PPL_W-1:0]         r_ppl;
    logic signed [PPH_W-1:0]  r_pph;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [Q_W-1:0]    r_q;
    logic signed [X_W-1:0]    r_x;
    logic [RES_W-1:0]         r_p;
    logic [RES_W-1:0]         r_temp_out;

    logic signed [DT_W-1:0]   n_dt;
    logic signed [MT_W-1:0]   n_mt, n_mo, n_ms;
    logic signed [63:0]       n_temp64, n_off64, n_sens64;
    logic signed [PPL_W:0]    n_ppl_s;
    logic signed [PPH_W-1:0]  n_pph;
    logic signed [63:0]       n_prod64, n_q64, n_x64, n_p64;

    function automatic logic signed [63:0] f_trunc_shr(input logic signed [63:0] v,
                                                       input logic [5:0] k);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (v + bias) >>> k;
    endfunction

    bptc_cal_regs u_cal (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cal      (w_cal)
    );

    assign o_cfg_ready   = 1'b1;
    assign w_en          = !r_vld[N_STAGE-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        n_dt = $signed({1'b0, s_axis_tdata[47:24]})
             - $signed({1'b0, w_cal.c5, C5_SHIFT'(0)});

        n_mt = r_dt * $signed({1'b0, w_cal.c6});
        n_mo = r_dt * $signed({1'b0, w_cal.c4});
        n_ms = r_dt * $signed({1'b0, w_cal.c3});

        n_temp64 = 64'(TEMP_BASE) + f_trunc_shr(64'(r_mt), 6'(T_SHIFT));
        n_off64  = ($signed({48'b0, w_cal.c2}) <<< C2_SHIFT)
                 + f_trunc_shr(64'(r_mo), 6'(OFF_SHIFT));
        n_sens64 = ($signed({48'b0, w_cal.c1}) <<< C1_SHIFT)
                 + f_trunc_shr(64'(r_ms), 6'(SENS_SHIFT));

        // sensitivity split into unsigned low and signed high halves
        n_ppl_s = $signed({1'b0, r_d1_s3}) * $signed({1'b0, r_sens[LO_W-1:0]});
        n_pph   = $signed({1'b0, r_d1_s3}) * $signed(r_sens[SENS_W-1:LO_W]);

        n_prod64 = (64'(r_pph) <<< LO_W) + $signed({{(64-PPL_W){1'b0}}, r_ppl});
        n_q64    = f_trunc_shr(64'(r_prod), 6'(P1_SHIFT));
        n_x64    = 64'(r_q) - 64'(r_off_s6);
        n_p64    = f_trunc_shr(64'(r_x), 6'(P2_SHIFT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STAGE-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1
            r_dt       <= n_dt;
            r_d1_s1    <= s_axis_tdata[23:0];
            // stage 2
            r_mt       <= n_mt;
            r_mo       <= n_mo;
            r_ms       <= n_ms;
            r_d1_s2    <= r_d1_s1;
            // stage 3
            r_temp_s3  <= n_temp64[RES_W-1:0];
            r_off_s3   <= n_off64[OFF_W-1:0];
            r_sens     <= n_sens64[SENS_W-1:0];
            r_d1_s3    <= r_d1_s2;
            // stage 4
            r_ppl      <= n_ppl_s[PPL_W-1:0];
            r_pph      <= n_pph;
            r_off_s4   <= r_off_s3;
            r_temp_s4  <= r_temp_s3;
            // stage 5
            r_prod     <= n_prod64[PROD_W-1:0];
            r_off_s5   <= r_off_s4;
            r_temp_s5  <= r_temp_s4;
            // stage 6
            r_q        <= n_q64[Q_W-1:0];
            r_off_s6   <= r_off_s5;
            r_temp_s6  <= r_temp_s5;
            // stage 7
            r_x        <= n_x64[X_W-1:0];
            r_temp_s7  <= r_temp_s6;
            // stage 8, output word
            r_p        <= n_p64[RES_W-1:0];
            r_temp_out <= r_temp_s7;
        end
    end

    assign m_axis_tvalid = r_vld[N_STAGE-1];
    assign m_axis_tdata  = {r_p, r_temp_out};

    `ASSERT_CLK(a_accept_enters, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> r_vld[0], "accepted word missing from first stage")
    `ASSERT_CLK(a_stall_freezes, i_clk, i_rst_n, !w_en |=> $stable(r_vld), "pipeline moved during output stall")
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid straight after reset")

endmodule

`default_nettype wire
